// ----- hw/rtl/slns_pkg.sv -----
package slns_pkg;

	localparam int RING_DEPTH_DEF = 64;

	localparam int WORD_W  = 32;
	localparam int LEAK_W  = 16;
	localparam int GAIN_W  = 31;
	localparam int SLOPE_W = 24;
	localparam int EXP_W   = 4;
	localparam int REFR_W  = 10;
	localparam int DELAY_W = 6;
	localparam int DRAW_W  = 16;
	localparam int CMD_W   = 2;
	localparam int CFG_IDX_W = 3;

	// shared multiplier operands: signed, wide enough for unsigned 32-bit excess
	localparam int MUL_W  = WORD_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	// Q16.16 one, probability width
	localparam int PROB_W = 17;
	localparam logic [PROB_W-1:0] ONE_Q16 = 17'h1_0000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_SYNAPSE = 2'd1,
		CMD_CURRENT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEAK      = 3'd0,
		REG_GAIN      = 3'd1,
		REG_THRESHOLD = 3'd2,
		REG_SLOPE     = 3'd3,
		REG_EXPONENT  = 3'd4,
		REG_RESET_POT = 3'd5,
		REG_REFRACT   = 3'd6,
		REG_UNUSED    = 3'd7
	} cfg_reg_t;

	localparam logic [LEAK_W-1:0]  LEAK_RST  = 16'd62000;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 31'd6554;
	localparam logic [SLOPE_W-1:0] SLOPE_RST = 24'd6554;
	localparam logic [EXP_W-1:0]   EXP_RST   = 4'd1;
	localparam logic [REFR_W-1:0]  REFR_RST  = 10'd20;

endpackage

// ----- hw/rtl/slns_ring.sv -----
module slns_ring #(
	parameter int DEPTH = slns_pkg::RING_DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [slns_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [slns_pkg::WORD_W-1:0] rdata
);
	import slns_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-before-write on a same-address collision
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/slns_mul.sv -----
module slns_mul (
	input  logic                               clk,
	input  logic signed [slns_pkg::MUL_W-1:0]  a,
	input  logic signed [slns_pkg::MUL_W-1:0]  b,
	output logic signed [slns_pkg::PROD_W-1:0] prod
);
	import slns_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ----- hw/rtl/stochastic_leaky_neuron_step_core.sv -----
// Discrete-time stochastic leaky neuron. Commands enter one at a time on the in
// channel; only a tick (command 0) produces an out beat. A set-current command
// or the unused command is taken without leaving the idle state. A synaptic
// command passes through the fold and write states, folding pos+delay back
// into the ring one wrap at a time (at most one fold when RING_DEPTH >= 64).
// A refractory tick goes straight to the done state. A normal tick runs leak,
// drive, excess and each power step one after another through a single
// registered 33x33 multiplier; the power steps are skipped when the potential
// is at or below threshold or the scaled excess reaches 1.0. The result sits
// in an output register, so the next command is taken while it waits; a later
// tick stalls only if that register is still full. After reset both delay
// rings are swept to zero, one slot at a time, with in_ready low.
// Configuration writes are always accepted but belong only where no command is
// in flight.
module stochastic_leaky_neuron_step_core #(
	parameter int RING_DEPTH = slns_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [slns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [slns_pkg::WORD_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [slns_pkg::CMD_W-1:0]     command,
	input  logic signed [slns_pkg::WORD_W-1:0] weight,
	input  logic [slns_pkg::DELAY_W-1:0]   delay,
	input  logic signed [slns_pkg::WORD_W-1:0] current_value,
	input  logic [slns_pkg::DRAW_W-1:0]    random_draw,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           fired,
	output logic signed [slns_pkg::WORD_W-1:0] fire_potential,
	output logic signed [slns_pkg::WORD_W-1:0] membrane_potential,
	output logic signed [slns_pkg::WORD_W-1:0] synaptic_sum
);
	import slns_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int SW = ((PW > DELAY_W) ? PW : DELAY_W) + 1;
	localparam int ACC_W = 48;
	localparam logic [PW-1:0] POS_LAST = PW'(RING_DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);
	localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh0000_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -48'sh0000_8000_0000;

	typedef enum logic [12:0] {
		ST_CLEAR  = 13'b0000000000001,
		ST_IDLE   = 13'b0000000000010,
		ST_FOLD   = 13'b0000000000100,
		ST_SYN_WR = 13'b0000000001000,
		ST_LEAK   = 13'b0000000010000,
		ST_GAIN   = 13'b0000000100000,
		ST_SUM    = 13'b0000001000000,
		ST_SAT    = 13'b0000010000000,
		ST_XMUL   = 13'b0000100000000,
		ST_XCHK   = 13'b0001000000000,
		ST_POW    = 13'b0010000000000,
		ST_CMP    = 13'b0100000000000,
		ST_DONE   = 13'b1000000000000
	} state_t;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > ACC_MAX) begin
			r = ACC_MAX[WORD_W-1:0];
		end else if (v < ACC_MIN) begin
			r = ACC_MIN[WORD_W-1:0];
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	// configuration
	logic [LEAK_W-1:0]        leak_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [WORD_W-1:0] thr_q;
	logic [SLOPE_W-1:0]       slope_q;
	logic [EXP_W-1:0]         exp_q;
	logic signed [WORD_W-1:0] rst_pot_q;
	logic [REFR_W-1:0]        refr_ticks_q;

	// neuron state
	state_t                   state_q;
	logic [PW-1:0]            clr_q;
	logic [PW-1:0]            pos_q;
	logic signed [WORD_W-1:0] potential_q;
	logic signed [WORD_W-1:0] drive_q;
	logic [REFR_W-1:0]        refr_q;

	// per-command working registers
	logic [SW-1:0]            slot_q;
	logic signed [WORD_W-1:0] weight_q;
	logic [DRAW_W-1:0]        draw_q;
	logic signed [WORD_W-1:0] exc_q;
	logic signed [WORD_W-1:0] inh_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [WORD_W-1:0] vnew_q;
	logic [DRAW_W-1:0]        x_q;
	logic [EXP_W-1:0]         k_q;
	logic [PROB_W-1:0]        p_q;
	logic                     fired_q;
	logic signed [WORD_W-1:0] fv_q;
	logic signed [WORD_W-1:0] syn_q;

	// output register
	logic                     out_valid_q;
	logic                     out_fired_q;
	logic signed [WORD_W-1:0] out_fv_q;
	logic signed [WORD_W-1:0] out_pot_q;
	logic signed [WORD_W-1:0] out_syn_q;

	// ring ports
	logic                     exc_we, inh_we;
	logic [PW-1:0]            waddr, raddr;
	logic [WORD_W-1:0]        exc_wdata, inh_wdata;
	logic [WORD_W-1:0]        exc_rdata, inh_rdata;

	// multiplier
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;

	logic                     in_fire;
	logic [PW-1:0]            pos_next;
	logic signed [MUL_W-1:0]  diff;
	logic [PROB_W-1:0]        p_cur;
	logic signed [WORD_W:0]   syn_add;
	logic signed [WORD_W-1:0] syn_sat;
	logic signed [ACC_W-1:0]  prod_sh;
	logic                     fire_now;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign pos_next  = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;

	assign diff    = {vnew_q[WORD_W-1], vnew_q} - {thr_q[WORD_W-1], thr_q};
	assign p_cur   = (k_q == '0) ? ONE_Q16 : prod[PROB_W+15:16];
	assign prod_sh = ACC_W'(prod >>> 16);
	assign syn_add = (weight_q > 0) ? ({exc_rdata[WORD_W-1], exc_rdata} +
			{weight_q[WORD_W-1], weight_q}) :
			({inh_rdata[WORD_W-1], inh_rdata} + {weight_q[WORD_W-1], weight_q});
	assign syn_sat  = sat32(ACC_W'(syn_add));
	assign fire_now = (p_q != '0) && (p_q >= PROB_W'(draw_q));

	slns_ring #(.DEPTH(RING_DEPTH), .AW(PW)) u_exc_ring (
		.clk(clk), .we(exc_we), .waddr(waddr), .wdata(exc_wdata),
		.raddr(raddr), .rdata(exc_rdata)
	);

	slns_ring #(.DEPTH(RING_DEPTH), .AW(PW)) u_inh_ring (
		.clk(clk), .we(inh_we), .waddr(waddr), .wdata(inh_wdata),
		.raddr(raddr), .rdata(inh_rdata)
	);

	slns_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	// ring access control
	always_comb begin
		exc_we    = 1'b0;
		inh_we    = 1'b0;
		waddr     = pos_q;
		exc_wdata = '0;
		inh_wdata = '0;
		raddr     = pos_q;
		unique case (state_q)
			ST_CLEAR: begin
				exc_we = 1'b1;
				inh_we = 1'b1;
				waddr  = clr_q;
			end
			ST_IDLE: begin
				// refractory tick clears the current slot right away
				if (in_fire && command == CMD_TICK && refr_q != '0) begin
					exc_we = 1'b1;
					inh_we = 1'b1;
				end
			end
			ST_FOLD: begin
				raddr = slot_q[PW-1:0];
			end
			ST_SYN_WR: begin
				waddr = slot_q[PW-1:0];
				if (weight_q > 0) begin
					exc_we    = 1'b1;
					exc_wdata = syn_sat;
				end else begin
					inh_we    = 1'b1;
					inh_wdata = syn_sat;
				end
			end
			ST_LEAK: begin
				exc_we = 1'b1;
				inh_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_LEAK: begin
				mul_a = {potential_q[WORD_W-1], potential_q};
				mul_b = MUL_W'(leak_q);
			end
			ST_GAIN: begin
				mul_a = {drive_q[WORD_W-1], drive_q};
				mul_b = MUL_W'(gain_q);
			end
			ST_XMUL: begin
				mul_a = diff;
				mul_b = MUL_W'(slope_q);
			end
			ST_POW: begin
				mul_a = MUL_W'(p_cur);
				mul_b = MUL_W'(x_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_q       <= LEAK_RST;
			gain_q       <= GAIN_RST;
			thr_q        <= '0;
			slope_q      <= SLOPE_RST;
			exp_q        <= EXP_RST;
			rst_pot_q    <= '0;
			refr_ticks_q <= REFR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEAK:      leak_q       <= cfg_data[LEAK_W-1:0];
				REG_GAIN:      gain_q       <= cfg_data[GAIN_W-1:0];
				REG_THRESHOLD: thr_q        <= cfg_data;
				REG_SLOPE:     slope_q      <= cfg_data[SLOPE_W-1:0];
				REG_EXPONENT:  exp_q        <= cfg_data[EXP_W-1:0];
				REG_RESET_POT: rst_pot_q    <= cfg_data;
				REG_REFRACT:   refr_ticks_q <= cfg_data[REFR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pos_q       <= '0;
			potential_q <= '0;
			drive_q     <= '0;
			refr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new beat may replace the one taken in the same cycle
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == POS_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						priority case (command)
							CMD_SYNAPSE: begin
								slot_q   <= SW'(pos_q) + SW'(delay);
								weight_q <= weight;
								state_q  <= ST_FOLD;
							end
							CMD_CURRENT: begin
								drive_q <= current_value;
							end
							CMD_TICK: begin
								draw_q <= random_draw;
								if (refr_q != '0) begin
									refr_q  <= refr_q - 1'b1;
									drive_q <= '0;
									pos_q   <= pos_next;
									fired_q <= 1'b0;
									fv_q    <= '0;
									syn_q   <= '0;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_LEAK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FOLD: begin
					// one wrap per cycle; leaves once the slot is in range
					if (slot_q >= DEPTH_S) begin
						slot_q <= slot_q - DEPTH_S;
					end else begin
						state_q <= ST_SYN_WR;
					end
				end
				ST_SYN_WR: begin
					state_q <= ST_IDLE;
				end
				ST_LEAK: begin
					exc_q   <= exc_rdata;
					inh_q   <= inh_rdata;
					pos_q   <= pos_next;
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					acc_q   <= prod_sh + ACC_W'(exc_q) + ACC_W'(inh_q);
					syn_q   <= sat32(ACC_W'(exc_q) + ACC_W'(inh_q));
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					acc_q   <= acc_q + prod_sh;
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					vnew_q  <= sat32(acc_q);
					state_q <= ST_XMUL;
				end
				ST_XMUL: begin
					if (diff[MUL_W-1] || diff == '0) begin
						p_q     <= '0;
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_XCHK;
					end
				end
				ST_XCHK: begin
					// excess at or above 1.0 saturates the probability
					if (prod[PROD_W-1:32] != '0) begin
						p_q     <= ONE_Q16;
						state_q <= ST_CMP;
					end else begin
						x_q     <= prod[31:16];
						k_q     <= '0;
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (k_q == exp_q) begin
						p_q     <= p_cur;
						state_q <= ST_CMP;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_CMP: begin
					if (fire_now) begin
						fired_q     <= 1'b1;
						fv_q        <= vnew_q;
						potential_q <= rst_pot_q;
						refr_q      <= refr_ticks_q;
					end else begin
						fired_q     <= 1'b0;
						fv_q        <= '0;
						potential_q <= vnew_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_fired_q <= fired_q;
			out_fv_q    <= fv_q;
			out_pot_q   <= potential_q;
			out_syn_q   <= syn_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign fired              = out_fired_q;
	assign fire_potential     = out_fv_q;
	assign membrane_potential = out_pot_q;
	assign synaptic_sum       = out_syn_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import slns_pkg::*;

	localparam int RING_DEPTH = RING_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 60;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 118;

	typedef struct packed {
		cmd_t                      command;
		logic signed [WORD_W-1:0]  weight;
		logic [DELAY_W-1:0]        delay;
		logic signed [WORD_W-1:0]  current_value;
		logic [DRAW_W-1:0]         random_draw;
	} stim_t;

	typedef struct packed {
		logic                      fired;
		logic signed [WORD_W-1:0]  fire_v;
		logic signed [WORD_W-1:0]  vmem;
		logic signed [WORD_W-1:0]  syn;
	} tick_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_LEAK;
	logic [WORD_W-1:0] cfg_data = '0;

	logic in_valid = 1'b0;
	logic in_ready;
	cmd_t command = CMD_TICK;
	logic signed [WORD_W-1:0] weight = '0;
	logic [DELAY_W-1:0] delay = '0;
	logic signed [WORD_W-1:0] current_value = '0;
	logic [DRAW_W-1:0] random_draw = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic fired;
	logic signed [WORD_W-1:0] fire_potential;
	logic signed [WORD_W-1:0] membrane_potential;
	logic signed [WORD_W-1:0] synaptic_sum;

	always #5 clk = ~clk;

	stochastic_leaky_neuron_step_core i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.weight            (weight),
		.delay             (delay),
		.current_value     (current_value),
		.random_draw       (random_draw),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.fired             (fired),
		.fire_potential    (fire_potential),
		.membrane_potential(membrane_potential),
		.synaptic_sum      (synaptic_sum)
	);

	// neuron mirror: registers and state
	logic [LEAK_W-1:0]        leak_f;
	logic [GAIN_W-1:0]        gain_f;
	logic signed [WORD_W-1:0] thresh_v;
	logic [SLOPE_W-1:0]       slope_f;
	logic [EXP_W-1:0]         expo_n;
	logic signed [WORD_W-1:0] vreset_v;
	logic [REFR_W-1:0]        refr_len;

	logic signed [WORD_W-1:0] exc_ring [RING_DEPTH];
	logic signed [WORD_W-1:0] inh_ring [RING_DEPTH];
	logic signed [WORD_W-1:0] vmem;
	logic signed [WORD_W-1:0] idrive;
	logic [REFR_W-1:0]        refr_left;
	int                       ring_pos;

	stim_t        cmd_backlog[$];
	tick_report_t tick_reports[$];
	stim_t        cur_cmd;
	stim_t        nxt_cmd;
	tick_report_t want;

	int tx_wait = 0;
	int rx_wait = 0;
	int tx_mode = 0;
	int rx_mode = 0;
	int stall = 0;
	int quiet_cycles = 0;
	int n_cmds = 0;
	int n_ticks = 0;
	int n_spikes = 0;
	int n_cfg = 0;
	int n_errors = 0;

	function automatic logic signed [WORD_W-1:0] sat32(input longint x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[WORD_W-1:0];
	endfunction

	function automatic void neuron_reset();
		leak_f = LEAK_RST;
		gain_f = GAIN_RST;
		thresh_v = '0;
		slope_f = SLOPE_RST;
		expo_n = EXP_RST;
		vreset_v = '0;
		refr_len = REFR_RST;
		for (int i = 0; i < RING_DEPTH; i++) begin
			exc_ring[i] = '0;
			inh_ring[i] = '0;
		end
		vmem = '0;
		idrive = '0;
		refr_left = '0;
		ring_pos = 0;
	endfunction

	function automatic void reg_apply(input cfg_reg_t idx, input logic [WORD_W-1:0] d);
		case (idx)
		REG_LEAK:      leak_f = d[LEAK_W-1:0];
		REG_GAIN:      gain_f = d[GAIN_W-1:0];
		REG_THRESHOLD: thresh_v = d;
		REG_SLOPE:     slope_f = d[SLOPE_W-1:0];
		REG_EXPONENT:  expo_n = d[EXP_W-1:0];
		REG_RESET_POT: vreset_v = d;
		REG_REFRACT:   refr_len = d[REFR_W-1:0];
		default: ;
		endcase
	endfunction

	// (slope*(V-thr))^exponent in Q16.16, clipped to one; zero at or below threshold
	function automatic int fire_prob(input logic signed [WORD_W-1:0] v);
		longint diff;
		longint x;
		longint p;
		int k;
		diff = longint'(v) - longint'(thresh_v);
		if (diff <= 0)
			return 0;
		x = (longint'(slope_f) * diff) >>> 16;
		if (x >= longint'(ONE_Q16))
			return int'(ONE_Q16);
		p = longint'(ONE_Q16);
		for (k = 0; k < expo_n; k++)
			p = (p * x) >>> 16;
		return int'(p);
	endfunction

	function automatic void neuron_apply(input stim_t it);
		int slot;
		int prob;
		longint excv;
		longint inhv;
		longint acc;
		tick_report_t r;
		case (it.command)
		CMD_SYNAPSE: begin
			slot = (ring_pos + int'(it.delay)) % RING_DEPTH;
			if ($signed(it.weight) > 0)
				exc_ring[slot] = sat32(longint'(exc_ring[slot]) + longint'(it.weight));
			else
				inh_ring[slot] = sat32(longint'(inh_ring[slot]) + longint'(it.weight));
		end
		CMD_CURRENT: idrive = it.current_value;
		CMD_TICK: begin
			r = '0;
			if (refr_left > 0) begin
				refr_left = refr_left - 1'b1;
				exc_ring[ring_pos] = '0;
				inh_ring[ring_pos] = '0;
				idrive = '0;
			end else begin
				excv = longint'(exc_ring[ring_pos]);
				inhv = longint'(inh_ring[ring_pos]);
				r.syn = sat32(excv + inhv);
				acc = ((longint'(leak_f) * longint'(vmem)) >>> 16) + excv + inhv
					+ ((longint'(gain_f) * longint'(idrive)) >>> 16);
				vmem = sat32(acc);
				exc_ring[ring_pos] = '0;
				inh_ring[ring_pos] = '0;
				prob = fire_prob(vmem);
				if (prob != 0 && prob >= int'(it.random_draw)) begin
					r.fired = 1'b1;
					r.fire_v = vmem;
					vmem = vreset_v;
					refr_left = refr_len;
					n_spikes++;
				end
			end
			r.vmem = vmem;
			ring_pos = (ring_pos + 1) % RING_DEPTH;
			tick_reports.insert(tick_reports.size(), r);
		end
		default: ;
		endcase
	endfunction

	function automatic int draw_wait(input int mode);
		if (mode == 0)
			return 0;
		if (mode == 1 && $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic logic signed [WORD_W-1:0] q16_value(input int span);
		case ($urandom_range(0, 9))
		0: begin
			case ($urandom_range(0, 4))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			3: return 32'sh1;
			default: return 32'shffffffff;
			endcase
		end
		1: return $urandom();
		default: return int'($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	function automatic stim_t cmd_item(input cmd_t c, input logic [WORD_W-1:0] w,
		input int d, input logic [WORD_W-1:0] cur, input int r);
		stim_t it;
		it.command = c;
		it.weight = w;
		it.delay = DELAY_W'(d);
		it.current_value = cur;
		it.random_draw = DRAW_W'(r);
		return it;
	endfunction

	function automatic void queue_cmd(input stim_t it);
		cmd_backlog.insert(cmd_backlog.size(), it);
	endfunction

	function automatic stim_t random_cmd();
		stim_t it;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			it.command = CMD_TICK;
		else if (sel < 80)
			it.command = CMD_SYNAPSE;
		else if (sel < 95)
			it.command = CMD_CURRENT;
		else
			it.command = CMD_NONE;
		it.weight = q16_value(524288);
		it.delay = DELAY_W'($urandom_range(0, 63));
		// mostly positive drive so the neuron gets over threshold
		if ($urandom_range(0, 3) == 0)
			it.current_value = q16_value(524288);
		else
			it.current_value = int'($urandom_range(0, 524288));
		case ($urandom_range(0, 9))
		0: it.random_draw = '0;
		1: it.random_draw = '1;
		default: it.random_draw = DRAW_W'($urandom_range(0, 65535));
		endcase
		return it;
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				neuron_apply(cur_cmd);
				n_cmds++;
			end
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					tx_wait <= tx_wait - 1;
					in_valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					nxt_cmd = cmd_backlog.pop_front();
					cur_cmd <= nxt_cmd;
					command <= nxt_cmd.command;
					weight <= nxt_cmd.weight;
					delay <= nxt_cmd.delay;
					current_value <= nxt_cmd.current_value;
					random_draw <= nxt_cmd.random_draw;
					in_valid <= 1'b1;
					tx_wait <= draw_wait(tx_mode);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (tick_reports.size() == 0) begin
					$display("%0t: unexpected tick beat: fired=%0b vmem=%0d", $time, fired,
						membrane_potential);
					n_errors++;
				end else begin
					want = tick_reports.pop_front();
					if (fired !== want.fired) begin
						$display("%0t: fired exp %0b got %0b", $time, want.fired, fired);
						n_errors++;
					end
					if (fire_potential !== want.fire_v) begin
						$display("%0t: fire_potential exp %0d got %0d", $time, want.fire_v,
							fire_potential);
						n_errors++;
					end
					if (membrane_potential !== want.vmem) begin
						$display("%0t: membrane_potential exp %0d got %0d", $time, want.vmem,
							membrane_potential);
						n_errors++;
					end
					if (synaptic_sum !== want.syn) begin
						$display("%0t: synaptic_sum exp %0d got %0d", $time, want.syn,
							synaptic_sum);
						n_errors++;
					end
				end
				n_ticks++;
				// long hold-offs let the result register fill and back up the input
				if (n_ticks == 80 || n_ticks == 500)
					stall = HOLD_CYCLES;
				else
					stall = draw_wait(rx_mode);
				rx_wait <= stall;
				out_ready <= (stall == 0);
			end else if (rx_wait > 0) begin
				rx_wait <= rx_wait - 1;
				out_ready <= (rx_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		reg_apply(idx, d);
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	// drained and past the longest tick before any register write
	task automatic wait_quiet();
		while (cmd_backlog.size() != 0 || in_valid || tick_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int ph);
		case (ph)
		1: begin
			// low end, with junk above each narrow field
			write_reg(REG_LEAK, 32'hffff0000);
			write_reg(REG_GAIN, 32'h80000000);
			write_reg(REG_THRESHOLD, 32'h80000000);
			write_reg(REG_SLOPE, 32'hff000000);
			write_reg(REG_EXPONENT, 32'hfffffff0);
			write_reg(REG_RESET_POT, 32'h80000000);
			write_reg(REG_REFRACT, 32'hfffffc00);
		end
		2: begin
			write_reg(REG_LEAK, 32'hffffffff);
			write_reg(REG_GAIN, 32'hffffffff);
			write_reg(REG_THRESHOLD, 32'h7fffffff);
			write_reg(REG_SLOPE, 32'hffffffff);
			write_reg(REG_EXPONENT, 32'hffffffff);
			write_reg(REG_RESET_POT, 32'h7fffffff);
			write_reg(REG_REFRACT, 32'hffffffff);
		end
		default: begin
			write_reg(REG_LEAK, {16'($urandom), 16'($urandom_range(40000, 65535))});
			write_reg(REG_GAIN, {1'($urandom), 31'($urandom_range(0, 131072))});
			write_reg(REG_THRESHOLD, 32'(int'($urandom_range(0, 524288)) - 262144));
			write_reg(REG_SLOPE, {8'($urandom), 24'($urandom_range(0, 65536))});
			write_reg(REG_EXPONENT, {28'($urandom), 4'($urandom_range(0, 15))});
			write_reg(REG_RESET_POT, 32'(int'($urandom_range(0, 262144)) - 131072));
			// of the random settings, only the last has the longest refractory; it silences the rest
			write_reg(REG_REFRACT, {22'($urandom),
				(ph == PHASES) ? 10'd1023 : 10'($urandom_range(0, 25))});
		end
		endcase
		write_reg(REG_UNUSED, $urandom());
	endtask

	initial begin
		int ph;
		int k;
		stim_t it;
		neuron_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ignored command, ring saturation both ways, wrap of the
		// delay, no spike below threshold with a zero draw, forced spike, refractory ticks
		tx_mode = 1;
		rx_mode = 1;
		queue_cmd(cmd_item(CMD_NONE, 32'hffffffff, 63, 32'hffffffff, 65535));
		queue_cmd(cmd_item(CMD_SYNAPSE, 32'h7fffffff, 0, 0, 0));
		queue_cmd(cmd_item(CMD_SYNAPSE, 32'h7fffffff, 0, 0, 0));
		queue_cmd(cmd_item(CMD_SYNAPSE, 32'h80000000, 0, 0, 0));
		queue_cmd(cmd_item(CMD_SYNAPSE, 32'h80000000, 0, 0, 0));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 0));
		queue_cmd(cmd_item(CMD_SYNAPSE, 32'h0, 63, 0, 0));
		queue_cmd(cmd_item(CMD_SYNAPSE, 32'h1, 1, 0, 0));
		queue_cmd(cmd_item(CMD_SYNAPSE, 32'hffffffff, 32, 0, 0));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 0));
		queue_cmd(cmd_item(CMD_CURRENT, 0, 0, 32'h7fffffff, 0));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 65535));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 0));
		queue_cmd(cmd_item(CMD_CURRENT, 0, 0, 32'h80000000, 0));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 0));
		queue_cmd(cmd_item(CMD_NONE, 0, 0, 0, 0));
		queue_cmd(cmd_item(CMD_CURRENT, 0, 0, 32'd196608, 0));
		queue_cmd(cmd_item(CMD_SYNAPSE, 32'd131072, 63, 0, 0));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 1));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 32768));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 65535));
		queue_cmd(cmd_item(CMD_TICK, 0, 0, 0, 0));
		wait_quiet();

		for (ph = 1; ph <= PHASES; ph++) begin
			configure(ph);
			tx_mode = ph % 3;
			rx_mode = (ph / 3) % 3;
			k = 0;
			while (k < ITEMS_PER_PHASE) begin
				it = random_cmd();
				queue_cmd(it);
				if (it.command != CMD_NONE)
					k++;
			end
			wait_quiet();
		end

		$display("testbench: %0d commands taken, %0d tick beats checked, %0d spikes seen",
			n_cmds, n_ticks, n_spikes);
		$display("testbench: %0d register writes over %0d settings, both extremes included",
			n_cfg, PHASES + 1);
		if (n_errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/slns_pkg.sv
hw/rtl/slns_ring.sv
hw/rtl/slns_mul.sv
hw/rtl/stochastic_leaky_neuron_step_core.sv
tb/testbench.sv
